@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the sampler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset
`define GTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset
`define GTS_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/gts_pkg.sv @@
// Shared types and constants of the grid trilinear sampler
package gts_pkg;

	localparam int STORE_AW = 15;
	localparam int STORE_DEPTH = 1 << STORE_AW;
	localparam int VAL_W = 16;
	localparam int COORD_W = 16;
	localparam int SPC_W = 13;
	localparam int SQ_W = 2 * SPC_W;
	localparam int CUBE_W = 3 * SPC_W;
	localparam int ACC_W = CUBE_W + VAL_W;
	localparam int CFG_IW = 3;
	localparam int READ_COPIES = 4;

	typedef enum logic [CFG_IW-1:0] {
		REG_GRID_SPACING = 3'd0,
		REG_BOX_MIN_X    = 3'd1,
		REG_BOX_MAX_X    = 3'd2,
		REG_BOX_MIN_Y    = 3'd3,
		REG_BOX_MAX_Y    = 3'd4,
		REG_BOX_MIN_Z    = 3'd5,
		REG_BOX_MAX_Z    = 3'd6
	} cfg_reg_t;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Item tag carried through the position divider
	typedef struct packed {
		logic                  mode;
		logic                  inbox;
		logic [STORE_AW-1:0]   idx;
		logic [2*VAL_W-1:0]    data;
	} gts_tag_t;

endpackage

@@ rtl/core/grid_trilinear_sampler.sv @@
// Top level of the grid trilinear sampler: store, corner fetch, weighting, normalize
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, mode, entry_index, ...    | sink
//  out     | out_valid/out_ready, nutrient_out, growth_out| source
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data     | sink
//
// A query inside the box holds in_ready low while its eight corners are read in two halves,
// as they come from four copies of the grid store, each with one read port,
// four corners per read; a write or a query outside the box does not hold in_ready.
// A query's result reaches out_valid through 16 divider stages for the cell search,
// the address stage, two corner fetches, five weighting and sum stages, then
// 16 divider stages for the division by spacing cubed.
// Reset clears control state and the configuration registers; the grid store and data registers are not cleared.
// Back-pressure on out stalls the whole pipeline only when a result waits and the
// last stage also holds one; until then the pipeline keeps moving.
module grid_trilinear_sampler import gts_pkg::*; #(
	parameter int GRID_DIM = 32,
	parameter int COORD_FRAC_BITS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [STORE_AW-1:0] entry_index,
	input  logic [VAL_W-1:0]    nutrient_in,
	input  logic [VAL_W-1:0]    growth_in,
	input  logic [COORD_W-1:0]  pos_x,
	input  logic [COORD_W-1:0]  pos_y,
	input  logic [COORD_W-1:0]  pos_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VAL_W-1:0]    nutrient_out,
	output logic [VAL_W-1:0]    growth_out,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [COORD_W-1:0]  cfg_data
);

	`include "assert_macros.svh"

	localparam int CW = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
	localparam logic [CW-1:0] TOP = CW'(GRID_DIM - 1);
	localparam logic [STORE_AW-1:0] DIM_A = STORE_AW'(GRID_DIM);
	localparam logic [STORE_AW-1:0] DIM2_A = STORE_AW'(GRID_DIM * GRID_DIM);
	localparam logic [SPC_W-1:0] SPACING_RST = SPC_W'((10 << COORD_FRAC_BITS) & 8191);
	localparam int TAG_W = $bits(gts_tag_t);

	// ---------------- configuration registers ----------------
	logic [SPC_W-1:0]   spacing_q;
	logic [COORD_W-1:0] box_min_q [3];
	logic [COORD_W-1:0] box_max_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RST;
			for (int k = 0; k < 3; k++) begin
				box_min_q[k] <= '0;
				box_max_q[k] <= '1;
			end
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_SPACING: spacing_q <= cfg_data[SPC_W-1:0];
				REG_BOX_MIN_X:    box_min_q[0] <= cfg_data;
				REG_BOX_MAX_X:    box_max_q[0] <= cfg_data;
				REG_BOX_MIN_Y:    box_min_q[1] <= cfg_data;
				REG_BOX_MAX_Y:    box_max_q[1] <= cfg_data;
				REG_BOX_MIN_Z:    box_min_q[2] <= cfg_data;
				REG_BOX_MAX_Z:    box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// spacing of zero acts as one; its cube is precomputed in two steps
	logic [SPC_W-1:0]  s_eff;
	logic [SQ_W-1:0]   s2_q;
	logic [CUBE_W-1:0] s3_q;

	assign s_eff = (spacing_q == '0) ? SPC_W'(1) : spacing_q;

	always_ff @(posedge clk) begin
		s2_q <= SQ_W'(s_eff) * SQ_W'(s_eff);
		s3_q <= CUBE_W'(s2_q) * CUBE_W'(s_eff);
	end

	// ---------------- pipeline control ----------------
	logic adv;       // back half advances
	logic a_adv;     // fetch stage and front advance
	logic ph_q;      // second fetch cycle of a query
	logic v_d2;
	logic v_s1;
	gts_tag_t tag_s1;
	logic rd_en, wr_en;

	assign adv = !(out_valid && !out_ready && v_d2);
	assign rd_en = adv && v_s1 && (tag_s1.mode == MODE_QUERY) && tag_s1.inbox;
	assign wr_en = adv && v_s1 && (tag_s1.mode == MODE_WRITE);
	assign a_adv = adv && !(rd_en && !ph_q);
	assign in_ready = a_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 1'b0;
		end else if (rd_en) begin
			ph_q <= !ph_q;
		end
	end

	// ---------------- box check and cell search ----------------
	gts_tag_t         tag_in;
	logic [COORD_W-1:0] pos [3];
	logic [SPC_W-1:0] zrem [3];
	logic [SPC_W-1:0] rem1 [3];
	logic [COORD_W-1:0] q1 [3];
	logic             v_d1;
	logic [TAG_W-1:0] tag_d1;

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	always_comb begin
		tag_in.mode = mode;
		tag_in.idx = entry_index;
		tag_in.data = {growth_in, nutrient_in};
		tag_in.inbox = 1'b1;
		for (int k = 0; k < 3; k++) begin
			zrem[k] = '0;
			if (!(pos[k] > box_min_q[k] && pos[k] < box_max_q[k])) begin
				tag_in.inbox = 1'b0;
			end
		end
	end

	gts_div #(.LANES(3), .DW(SPC_W), .QW(COORD_W), .TW(TAG_W)) u_cell_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (a_adv),
		.v_i    (in_valid),
		.tag_i  (tag_in),
		.den    (s_eff),
		.rem_i  (zrem),
		.bits_i (pos),
		.v_o    (v_d1),
		.tag_o  (tag_d1),
		.q_o    (q1),
		.rem_o  (rem1)
	);

	// ---------------- corner addresses and weights (stage 1) ----------------
	function automatic logic [STORE_AW-1:0] corner_addr(input logic [CW-1:0] x,
			input logic [CW-1:0] y, input logic [CW-1:0] z);
		corner_addr = STORE_AW'(x) + DIM_A * STORE_AW'(y) + DIM2_A * STORE_AW'(z);
	endfunction

	logic [CW-1:0]       lo [3];
	logic [CW-1:0]       hi [3];
	logic [STORE_AW-1:0] addr_s1 [8];
	logic [SPC_W-1:0]    wr_s1 [3];
	logic [SPC_W-1:0]    wl_s1 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lo[k] = (q1[k] > COORD_W'(GRID_DIM - 1)) ? TOP : q1[k][CW-1:0];
			hi[k] = (lo[k] == TOP) ? TOP : CW'(lo[k] + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (a_adv) begin
			v_s1 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (a_adv) begin
			tag_s1 <= gts_tag_t'(tag_d1);
			for (int c = 0; c < 8; c++) begin
				addr_s1[c] <= corner_addr(c[0] ? hi[0] : lo[0], c[1] ? hi[1] : lo[1],
					c[2] ? hi[2] : lo[2]);
			end
			for (int k = 0; k < 3; k++) begin
				wr_s1[k] <= rem1[k];
				wl_s1[k] <= s_eff - rem1[k];
			end
		end
	end

	// ---------------- grid store: four copies, same writes ----------------
	// corners 0..3 (z low) are read in the first fetch phase, 4..7 in the second
	logic [2*VAL_W-1:0] rd_q [READ_COPIES];
	logic [2*VAL_W-1:0] lo_hold_q [READ_COPIES];

	for (genvar k = 0; k < READ_COPIES; k++) begin : g_copy
		logic [2*VAL_W-1:0] mem [STORE_DEPTH];
		logic [STORE_AW-1:0] raddr;
		assign raddr = ph_q ? addr_s1[k+READ_COPIES] : addr_s1[k];
		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[tag_s1.idx] <= tag_s1.data;
			end
			if (rd_en) begin
				rd_q[k] <= mem[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en && ph_q) begin
			lo_hold_q <= rd_q;
		end
	end

	// ---------------- stage 2: corners land ----------------
	logic             v_s2;
	logic [SPC_W-1:0] wr_s2 [3];
	logic [SPC_W-1:0] wl_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= rd_en && ph_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s2 <= wr_s1;
			wl_s2 <= wl_s1;
		end
	end

	// ---------------- stage 3: xy weights, corner values ----------------
	logic             v_s3;
	logic [SQ_W-1:0]  wxy_s3 [4];
	logic [SPC_W-1:0] wz_s3 [2];
	logic [VAL_W-1:0] n_s3 [8];
	logic [VAL_W-1:0] g_s3 [8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				wxy_s3[c] <= SQ_W'(c[0] ? wr_s2[0] : wl_s2[0]) *
					SQ_W'(c[1] ? wr_s2[1] : wl_s2[1]);
				n_s3[c] <= lo_hold_q[c][VAL_W-1:0];
				g_s3[c] <= lo_hold_q[c][2*VAL_W-1:VAL_W];
				n_s3[c+4] <= rd_q[c][VAL_W-1:0];
				g_s3[c+4] <= rd_q[c][2*VAL_W-1:VAL_W];
			end
			wz_s3[0] <= wl_s2[2];
			wz_s3[1] <= wr_s2[2];
		end
	end

	// ---------------- stage 4: full corner weights ----------------
	logic              v_s4;
	logic [CUBE_W-1:0] w_s4 [8];
	logic [VAL_W-1:0]  n_s4 [8];
	logic [VAL_W-1:0]  g_s4 [8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 8; c++) begin
				w_s4[c] <= CUBE_W'(wxy_s3[c[1:0]]) * CUBE_W'(wz_s3[c[2]]);
			end
			n_s4 <= n_s3;
			g_s4 <= g_s3;
		end
	end

	// ---------------- stage 5: weighted values ----------------
	logic             v_s5;
	logic [ACC_W-1:0] pn_s5 [8];
	logic [ACC_W-1:0] pg_s5 [8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 8; c++) begin
				pn_s5[c] <= ACC_W'(w_s4[c]) * ACC_W'(n_s4[c]);
				pg_s5[c] <= ACC_W'(w_s4[c]) * ACC_W'(g_s4[c]);
			end
		end
	end

	// ---------------- stages 6, 7: accumulate (sum fits, weights total s^3) ----
	logic             v_s6, v_s7;
	logic [ACC_W-1:0] sn_s6 [4];
	logic [ACC_W-1:0] sg_s6 [4];
	logic [ACC_W-1:0] tot_s7 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				sn_s6[j] <= pn_s5[2*j] + pn_s5[2*j+1];
				sg_s6[j] <= pg_s5[2*j] + pg_s5[2*j+1];
			end
			tot_s7[0] <= (sn_s6[0] + sn_s6[1]) + (sn_s6[2] + sn_s6[3]);
			tot_s7[1] <= (sg_s6[0] + sg_s6[1]) + (sg_s6[2] + sg_s6[3]);
		end
	end

	// ---------------- normalize: divide by s^3 ----------------
	// upper part of each sum is below s^3, so 16 quotient bits suffice
	logic [CUBE_W-1:0] nrem_i [2];
	logic [VAL_W-1:0]  nbits_i [2];
	logic [VAL_W-1:0]  q2 [2];
	logic [CUBE_W-1:0] rem2 [2];
	logic [0:0]        tag_d2;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			nrem_i[l] = tot_s7[l][ACC_W-1:VAL_W];
			nbits_i[l] = tot_s7[l][VAL_W-1:0];
		end
	end

	gts_div #(.LANES(2), .DW(CUBE_W), .QW(VAL_W), .TW(1)) u_norm_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_i    (v_s7),
		.tag_i  (1'b0),
		.den    (s3_q),
		.rem_i  (nrem_i),
		.bits_i (nbits_i),
		.v_o    (v_d2),
		.tag_o  (tag_d2),
		.q_o    (q2),
		.rem_o  (rem2)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if ((!out_valid || out_ready) && v_d2 && !tag_d2[0]) begin
			nutrient_out <= q2[0];
			growth_out <= q2[1];
		end
	end

	logic rem_unused;
	assign rem_unused = ^{rem2[0], rem2[1]};

	// ---------------- checks ----------------
	`GTS_ASSERT(a_phase_query, ph_q |-> (v_s1 && tag_s1.mode == MODE_QUERY && tag_s1.inbox),
		"fetch phase set without a query in the fetch stage")
	`GTS_ASSERT(a_phase_ends, (ph_q && adv) |=> !ph_q, "query fetch longer than two cycles")
	`GTS_NEVER(a_rd_wr_clash, rd_en && wr_en, "store read and write in the same cycle")
	`GTS_ASSERT(a_stall_cause, !adv |-> (out_valid && v_d2), "pipeline stalled without cause")

endmodule

@@ rtl/core/gts_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes, common divisor
module gts_div import gts_pkg::*; #(
	parameter int LANES = 3,
	parameter int DW = 13,
	parameter int QW = 16,
	parameter int TW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_i,
	input  logic [TW-1:0]    tag_i,
	input  logic [DW-1:0]    den,
	input  logic [DW-1:0]    rem_i [LANES],
	input  logic [QW-1:0]    bits_i [LANES],
	output logic             v_o,
	output logic [TW-1:0]    tag_o,
	output logic [QW-1:0]    q_o [LANES],
	output logic [DW-1:0]    rem_o [LANES]
);

	logic             v_s [QW];
	logic [TW-1:0]    tag_s [QW];
	logic [DW-1:0]    rem_s [QW][LANES];
	logic [QW-1:0]    bits_s [QW][LANES];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic             v_src;
		logic [TW-1:0]    tag_src;
		logic [DW-1:0]    rem_src [LANES];
		logic [QW-1:0]    bits_src [LANES];

		if (k == 0) begin : g_first
			assign v_src = v_i;
			assign tag_src = tag_i;
			assign rem_src = rem_i;
			assign bits_src = bits_i;
		end else begin : g_next
			assign v_src = v_s[k-1];
			assign tag_src = tag_s[k-1];
			assign rem_src = rem_s[k-1];
			assign bits_src = bits_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_src;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DW:0] trial;
			logic        ge;
			assign trial = {rem_src[l], bits_src[l][QW-1]};
			assign ge = trial >= {1'b0, den};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
					bits_s[k][l] <= {bits_src[l][QW-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k] <= tag_src;
			end
		end
	end

	assign v_o = v_s[QW-1];
	assign tag_o = tag_s[QW-1];
	assign q_o = bits_s[QW-1];
	assign rem_o = rem_s[QW-1];

endmodule

@@ verif/grid_trilinear_sampler_tb.sv @@
// Self-checking testbench for the grid trilinear sampler
module grid_trilinear_sampler_tb;
	import gts_pkg::*;

	localparam int DIM       = 32;
	localparam int TAIL_WAIT = 80;    // drain wait after the last sample
	localparam int IDLE_MAX  = 5000;  // cycles with no beat on any channel
	localparam int HOLD_LEN  = 400;   // long receiver hold-off

	typedef struct {
		logic                 op;
		logic [STORE_AW-1:0]  idx;
		logic [VAL_W-1:0]     nut;
		logic [VAL_W-1:0]     gro;
		logic [COORD_W-1:0]   p [3];
	} grid_item_t;

	typedef struct {
		logic [VAL_W-1:0] nut;
		logic [VAL_W-1:0] gro;
	} sample_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                mode = MODE_WRITE;
	logic [STORE_AW-1:0] entry_index = '0;
	logic [VAL_W-1:0]    nutrient_in = '0;
	logic [VAL_W-1:0]    growth_in = '0;
	logic [COORD_W-1:0]  pos_x = '0;
	logic [COORD_W-1:0]  pos_y = '0;
	logic [COORD_W-1:0]  pos_z = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [VAL_W-1:0]    nutrient_out;
	logic [VAL_W-1:0]    growth_out;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index = REG_GRID_SPACING;
	logic [COORD_W-1:0]  cfg_data = '0;

	grid_trilinear_sampler dut (.*);

	always #5 clk = ~clk;

	// stimulus waiting for the driver, and samples waiting for the output
	grid_item_t pending_items[$];
	sample_t    pending_samples[$];

	// shadow of the block: grid contents and register file
	logic [31:0]  grid_mirror [STORE_DEPTH];
	logic [15:0]  reg_mirror [7];
	// entries covered by a queued write; queries only touch these
	bit           entry_written [STORE_DEPTH];

	int  mismatches = 0;
	int  idle_cycles = 0;
	bit  in_beat = 1'b0;
	bit  hold_req = 1'b0;

	// Trilinear interpolation as the block computes it. Returns 0 when the
	// point falls outside the box (exclusive bounds), so no sample comes out.
	function automatic bit interp_sample(grid_item_t it, output sample_t smp);
		longint unsigned s, s3, acc_n, acc_g, w;
		int unsigned lo [3], hi [3], wr [3], wl [3], cell_i, pv;
		int unsigned cx, cy, cz;
		logic [31:0] e;
		acc_n = 0;
		acc_g = 0;
		smp.nut = '0;
		smp.gro = '0;
		for (int k = 0; k < 3; k++) begin
			pv = it.p[k];
			if (!(pv > reg_mirror[1 + 2*k] && pv < reg_mirror[2 + 2*k]))
				return 1'b0;
		end
		// zero spacing acts as one
		s = (reg_mirror[REG_GRID_SPACING][12:0] == 0) ? 1 : reg_mirror[REG_GRID_SPACING][12:0];
		for (int k = 0; k < 3; k++) begin
			pv = it.p[k];
			cell_i = pv / s;
			wr[k] = pv % s;
			wl[k] = s - wr[k];
			// clamp both corners at the grid edge
			lo[k] = (cell_i > DIM - 1) ? DIM - 1 : cell_i;
			hi[k] = (lo[k] + 1 > DIM - 1) ? DIM - 1 : lo[k] + 1;
		end
		for (int c = 0; c < 8; c++) begin
			cx = c[0] ? hi[0] : lo[0];
			cy = c[1] ? hi[1] : lo[1];
			cz = c[2] ? hi[2] : lo[2];
			w = longint'(c[0] ? wr[0] : wl[0]) * (c[1] ? wr[1] : wl[1]) *
				(c[2] ? wr[2] : wl[2]);
			e = grid_mirror[(cx + DIM*cy + DIM*DIM*cz) % STORE_DEPTH];
			acc_n += w * e[15:0];
			acc_g += w * e[31:16];
		end
		s3 = s * s * s;
		smp.nut = 16'(acc_n / s3);
		smp.gro = 16'(acc_g / s3);
		return 1'b1;
	endfunction

	// ---------------- input side: predictor, checker, watchdog ----------------
	always @(posedge clk) begin
		grid_item_t it;
		sample_t    smp;
		sample_t    want;
		in_beat <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				reg_mirror[cfg_index] = cfg_data;
			if (in_valid && in_ready) begin
				it.op = mode;
				it.idx = entry_index;
				it.nut = nutrient_in;
				it.gro = growth_in;
				it.p[0] = pos_x;
				it.p[1] = pos_y;
				it.p[2] = pos_z;
				if (it.op == MODE_WRITE)
					grid_mirror[it.idx] = {it.gro, it.nut};
				else if (interp_sample(it, smp))
					pending_samples.push_back(smp);
			end
			if (out_valid && out_ready) begin
				if (pending_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected sample nut=%h gro=%h", nutrient_out, growth_out);
				end else begin
					want = pending_samples.pop_front();
					if (want.nut !== nutrient_out || want.gro !== growth_out) begin
						mismatches++;
						if (mismatches <= 10)
							$display("sample mismatch: exp nut=%h gro=%h got nut=%h gro=%h",
								want.nut, want.gro, nutrient_out, growth_out);
					end
				end
			end
			// watchdog: any beat on any channel resets it
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= IDLE_MAX) begin
				$display("TB_ERROR");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------- driver: bursts with random gaps ----------------
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		grid_item_t it;
		if (arst_n && (!in_valid || in_beat)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				in_valid <= 1'b1;
				mode <= it.op;
				entry_index <= it.idx;
				nutrient_in <= it.nut;
				growth_in <= it.gro;
				pos_x <= it.p[0];
				pos_y <= it.p[1];
				pos_z <= it.p[2];
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					// a third of bursts run back to back
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else
					burst_left <= burst_left - 1;
			end else
				in_valid <= 1'b0;
		end
	end

	// ---------------- receiver: stall pattern plus long hold-off ----------------
	int stall_phase = 0;
	int stall_pct = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_req && hold_left == 0)
			hold_left <= HOLD_LEN;
		if (hold_left > 0) begin
			if (hold_left != 1 || !hold_req)
				hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				stall_phase <= 63;
				case ($urandom_range(0, 2))
					0: stall_pct <= 0;
					1: stall_pct <= 30;
					default: stall_pct <= 75;
				endcase
			end else
				stall_phase <= stall_phase - 1;
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ---------------- stimulus ----------------
	function automatic int unsigned spacing_now();
		return (reg_mirror[REG_GRID_SPACING][12:0] == 0) ? 1 :
			reg_mirror[REG_GRID_SPACING][12:0];
	endfunction

	// axis positions of the written region: the low four and the top two
	function automatic int unsigned region_axis(int unsigned n);
		return (n > 3) ? n + DIM - 6 : n;
	endfunction

	function automatic logic [STORE_AW-1:0] region_index();
		int unsigned a [3];
		for (int k = 0; k < 3; k++)
			a[k] = region_axis($urandom_range(0, 5));
		return STORE_AW'(a[0] + DIM*a[1] + DIM*DIM*a[2]);
	endfunction

	// true when the point is dropped or all eight of its corners are written
	function automatic bit corners_written(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z);
		int unsigned s, cell_i, pv [3], lo [3], hi [3], a;
		pv[0] = x;
		pv[1] = y;
		pv[2] = z;
		for (int k = 0; k < 3; k++)
			if (!(pv[k] > reg_mirror[1 + 2*k] && pv[k] < reg_mirror[2 + 2*k]))
				return 1'b1;
		s = spacing_now();
		for (int k = 0; k < 3; k++) begin
			cell_i = pv[k] / s;
			lo[k] = (cell_i > DIM - 1) ? DIM - 1 : cell_i;
			hi[k] = (lo[k] + 1 > DIM - 1) ? DIM - 1 : lo[k] + 1;
		end
		for (int c = 0; c < 8; c++) begin
			a = (c[0] ? hi[0] : lo[0]) + DIM*(c[1] ? hi[1] : lo[1]) +
				DIM*DIM*(c[2] ? hi[2] : lo[2]);
			if (!entry_written[a % STORE_DEPTH])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// coordinate inside a cell whose corners lie in the written region
	function automatic logic [COORD_W-1:0] cell_coord();
		int unsigned s, c, base, span;
		s = spacing_now();
		case ($urandom_range(0, 4))
			0: c = 0;
			1: c = 1;
			2: c = 2;
			3: c = DIM - 2;
			default: c = DIM - 1;   // past the grid edge: clamped
		endcase
		if (c * s > 65535)
			c = 0;
		base = c * s;
		if (c == DIM - 1)
			return COORD_W'($urandom_range(base, 65535));
		span = (base + s - 1 > 65535) ? 65535 - base : s - 1;
		return COORD_W'(base + $urandom_range(0, span));
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(int k);
		int unsigned lo, hi;
		lo = reg_mirror[1 + 2*k];
		hi = reg_mirror[2 + 2*k];
		case ($urandom_range(0, 19))
			0: return COORD_W'($urandom);
			1: return COORD_W'(lo);          // on the exclusive bound
			2: return COORD_W'(hi);
			3: begin
				if (hi > lo + 1)
					return COORD_W'($urandom_range(lo + 1, hi - 1));
				return cell_coord();
			end
			default: return cell_coord();
		endcase
	endfunction

	task automatic add_query(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		grid_item_t it;
		it.op = MODE_QUERY;
		it.idx = STORE_AW'($urandom);
		it.nut = VAL_W'($urandom);
		it.gro = VAL_W'($urandom);
		// a point that would touch an unwritten entry is moved onto the x bound
		it.p[0] = corners_written(x, y, z) ? x : reg_mirror[REG_BOX_MIN_X];
		it.p[1] = y;
		it.p[2] = z;
		pending_items.push_back(it);
	endtask

	task automatic add_write(logic [STORE_AW-1:0] idx, logic [15:0] n, logic [15:0] g);
		grid_item_t it;
		it.op = MODE_WRITE;
		it.idx = idx;
		it.nut = n;
		it.gro = g;
		for (int k = 0; k < 3; k++)
			it.p[k] = COORD_W'($urandom);
		entry_written[idx] = 1'b1;
		pending_items.push_back(it);
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			if ($urandom_range(0, 3) == 0)
				add_write(($urandom_range(0, 1) == 0) ? region_index() : STORE_AW'($urandom),
					VAL_W'($urandom), VAL_W'($urandom));
			else
				add_query(pick_coord(0), pick_coord(1), pick_coord(2));
	endtask

	// wait until all beats are in and every sample is out, then let the pipe drain
	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || pending_samples.size() > 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t r, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_regs(logic [12:0] spc, logic [15:0] b [6]);
		cfg_write(REG_GRID_SPACING, {3'b0, spc});
		cfg_write(REG_BOX_MIN_X, b[0]);
		cfg_write(REG_BOX_MAX_X, b[1]);
		cfg_write(REG_BOX_MIN_Y, b[2]);
		cfg_write(REG_BOX_MAX_Y, b[3]);
		cfg_write(REG_BOX_MIN_Z, b[4]);
		cfg_write(REG_BOX_MAX_Z, b[5]);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] full_box [6];
		logic [15:0] rnd_box [6];
		logic [15:0] empty_box [6];
		full_box = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
		empty_box = '{16'd1000, 16'd1000, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
		reg_mirror[REG_GRID_SPACING] = 16'd640;
		for (int k = 0; k < 3; k++) begin
			reg_mirror[1 + 2*k] = 16'd0;
			reg_mirror[2 + 2*k] = 16'hFFFF;
		end

		// written region: the low four and top two positions on each axis
		for (int az = 0; az < 6; az++)
			for (int ay = 0; ay < 6; ay++)
				for (int ax = 0; ax < 6; ax++)
					add_write(STORE_AW'(region_axis(ax) + DIM*region_axis(ay) +
						DIM*DIM*region_axis(az)), VAL_W'($urandom), VAL_W'($urandom));
		// directed corners of the coordinate space under reset registers
		add_query(16'd0, 16'd100, 16'd100);           // on the lower bound: dropped
		add_query(16'hFFFF, 16'd100, 16'd100);        // on the upper bound: dropped
		add_query(16'd1, 16'd1, 16'd1);
		add_query(16'hFFFE, 16'hFFFE, 16'hFFFE);      // far past grid edge: clamped
		add_query(16'd640, 16'd1280, 16'd1919);       // exact cell boundary, last step
		add_query(16'd19839, 16'd19840, 16'd20479);   // around the top cell
		add_query(16'h5555, 16'hAAAA, 16'h5555);
		add_query(16'hAAAA, 16'h5555, 16'hAAAA);
		add_write(STORE_AW'(0), 16'hFFFF, 16'hFFFF);
		add_write(STORE_AW'(32767), 16'h0000, 16'hFFFF);
		add_query(16'd5, 16'd5, 16'd5);
		add_query(16'hFFF0, 16'hFFF0, 16'hFFF0);
		add_query(16'd639, 16'd1, 16'd639);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_random(30);
		wait_idle();

		// smallest spacing, then the largest legal, zero, and the field maximum
		set_regs(13'd64, full_box);
		add_query(16'd65, 16'd127, 16'd2047);
		add_random(25);
		wait_idle();

		set_regs(13'd4096, full_box);
		add_query(16'd4095, 16'd4096, 16'd4097);
		add_random(25);
		wait_idle();

		set_regs(13'd0, full_box);   // zero spacing acts as one
		add_random(20);
		wait_idle();

		set_regs(13'h1FFF, full_box);
		add_random(20);
		wait_idle();

		// empty box: no query passes
		set_regs(13'd640, empty_box);
		add_random(15);
		wait_idle();

		// random boxes and spacing, one of them under a long output hold-off
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 3; k++) begin
				rnd_box[2*k] = 16'($urandom_range(0, 30000));
				rnd_box[2*k + 1] = 16'($urandom_range(rnd_box[2*k] + 2, 65535));
			end
			set_regs(13'($urandom_range(64, 4096)), rnd_box);
			if (ph == 1) begin
				hold_req = 1'b1;
				add_random(60);
				repeat (20) @(posedge clk);
				hold_req = 1'b0;
			end else
				add_random(20);
			wait_idle();
		end

		if (mismatches == 0 && pending_samples.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
